@@ rtl/core/tfc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tfc_pkg;

  localparam int WINDOW      = 20;
  localparam int MAX_DELAY   = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int ADDR_W = $clog2(MAX_DELAY);
  localparam int DIVC_W = $clog2(SUM_W);
  localparam int ENT_W  = 4 * SAMPLE_BITS;

  // register indexes
  localparam logic [2:0] REG_THRESH = 3'd0;
  localparam logic [2:0] REG_DELAY  = 3'd1;
  localparam logic [2:0] REG_LENGTH = 3'd2;
  localparam logic [2:0] REG_BASE   = 3'd3;
  localparam logic [2:0] REG_GAIN   = 3'd4;
  localparam logic [2:0] REG_OFFSET = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WIN, ST_DIV, ST_STORE, ST_READ, ST_MUL, ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic win;
    logic div_step;
    logic store;
    logic read;
    logic mul;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic rec;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [15:0] thresh;
    logic [9:0]  delay;
    logic [15:0] length;
    logic [15:0] base_idx;
    logic [23:0] gain;
    logic [15:0] offset;
  } cfg_t;

endpackage
`default_nettype wire

@@ rtl/core/tfc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tfc_ctrl
  import tfc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t sts,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_WIN;
      ST_WIN:   state_nxt = ST_DIV;
      ST_DIV:   if (sts.div_last) state_nxt = ST_STORE;
      ST_STORE: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_EMIT;
      ST_EMIT:  if (!sts.rec || sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_WIN:   cmd.win = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_STORE: cmd.store = 1'b1;
      ST_READ:  cmd.read = 1'b1;
      ST_MUL:   cmd.mul = 1'b1;
      ST_EMIT:  cmd.emit = sts.rec && sts.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/tfc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tfc_datapath
  import tfc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire cmd_t              cmd,
  output status_t                sts,
  input  wire logic [15:0]       in_pressure_code,
  input  wire logic [15:0]       in_ignition_code,
  input  wire logic [15:0]       in_arm_code,
  input  wire logic [15:0]       in_wheel_code,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [16:0]     out_time_offset,
  output logic signed [16:0]     out_pressure_value,
  output logic [15:0]            out_ignition_delayed,
  output logic signed [16:0]     out_arm_relative,
  output logic signed [16:0]     out_wheel_relative,
  output logic signed [16:0]     out_peak_pressure,
  output logic                   out_history_short,
  output logic                   out_last_record
);

  localparam logic signed [16:0] PEAK_MIN = 17'sh10000;

  // sample latch
  logic [SAMPLE_BITS-1:0] p_r, ig_r, a_r, w_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r  <= in_pressure_code[SAMPLE_BITS-1:0];
      ig_r <= in_ignition_code[SAMPLE_BITS-1:0];
      a_r  <= in_arm_code[SAMPLE_BITS-1:0];
      w_r  <= in_wheel_code[SAMPLE_BITS-1:0];
    end
  end

  // sample counter and window position
  logic [31:0]      n_r;
  logic [POS_W-1:0] pos_r;
  logic             warm;
  logic [CNT_W-1:0] cnt;
  assign warm = (n_r < 32'(WINDOW));
  assign cnt  = warm ? CNT_W'(n_r + 32'd1) : CNT_W'(WINDOW);

  // window taps
  logic [SAMPLE_BITS-1:0] pw_r [WINDOW];
  logic [SAMPLE_BITS-1:0] aw_r [WINDOW];
  logic [SAMPLE_BITS-1:0] ww_r [WINDOW];
  logic [SUM_W-1:0] ps_r, as_r, ws_r, ps_nxt, as_nxt, ws_nxt;
  logic [SAMPLE_BITS-1:0] p_old, a_old, w_old;

  assign p_old  = warm ? '0 : pw_r[pos_r];
  assign a_old  = warm ? '0 : aw_r[pos_r];
  assign w_old  = warm ? '0 : ww_r[pos_r];
  assign ps_nxt = ps_r - SUM_W'(p_old) + SUM_W'(p_r);
  assign as_nxt = as_r - SUM_W'(a_old) + SUM_W'(a_r);
  assign ws_nxt = ws_r - SUM_W'(w_old) + SUM_W'(w_r);

  always_ff @(posedge clk) begin
    if (cmd.win) begin
      pw_r[pos_r] <= p_r;
      aw_r[pos_r] <= a_r;
      ww_r[pos_r] <= w_r;
    end
  end

  // shared restoring divider, three lanes, one quotient bit per cycle
  logic [SUM_W-1:0]  pq_r, aq_r, wq_r;
  logic [CNT_W-1:0]  pr_r, ar_r, wr_r;
  logic [DIVC_W-1:0] divc_r;
  logic [CNT_W:0]    pt, at, wt;
  logic              pb, ab, wb;

  assign pt = {pr_r, pq_r[SUM_W-1]};
  assign at = {ar_r, aq_r[SUM_W-1]};
  assign wt = {wr_r, wq_r[SUM_W-1]};
  assign pb = (pt >= {1'b0, cnt});
  assign ab = (at >= {1'b0, cnt});
  assign wb = (wt >= {1'b0, cnt});
  assign sts.div_last = (divc_r == DIVC_W'(SUM_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.win) begin
      pq_r   <= ps_nxt;
      aq_r   <= as_nxt;
      wq_r   <= ws_nxt;
      pr_r   <= '0;
      ar_r   <= '0;
      wr_r   <= '0;
      divc_r <= '0;
    end else if (cmd.div_step) begin
      pq_r   <= {pq_r[SUM_W-2:0], pb};
      aq_r   <= {aq_r[SUM_W-2:0], ab};
      wq_r   <= {wq_r[SUM_W-2:0], wb};
      pr_r   <= pb ? CNT_W'(pt - {1'b0, cnt}) : pt[CNT_W-1:0];
      ar_r   <= ab ? CNT_W'(at - {1'b0, cnt}) : at[CNT_W-1:0];
      wr_r   <= wb ? CNT_W'(wt - {1'b0, cnt}) : wt[CNT_W-1:0];
      divc_r <= divc_r + 1'b1;
    end
  end

  logic [SAMPLE_BITS-1:0] pav, aav, wav;
  assign pav = pq_r[SAMPLE_BITS-1:0];
  assign aav = aq_r[SAMPLE_BITS-1:0];
  assign wav = wq_r[SAMPLE_BITS-1:0];

  // history memory; wp_r has already moved past the entry just stored
  logic [ENT_W-1:0]  store_mem [MAX_DELAY];
  logic [ENT_W-1:0]  rd_r;
  logic [ADDR_W-1:0] wp_r, rp;
  assign rp = wp_r - ADDR_W'(cfg.delay) - ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.store) store_mem[wp_r] <= {pav, ig_r, aav, wav};
    if (cmd.read)  rd_r <= store_mem[rp];
  end

  // capture control state
  logic        trig_r, done_r, rec_r, short_r, last_r;
  logic [15:0] recs_r, abase_r, wbase_r;
  logic [16:0] to_r;
  logic        trig_now, rec_now;
  logic [15:0] len;
  assign trig_now = trig_r || (!done_r && (ig_r < cfg.thresh));
  assign rec_now  = trig_now && !done_r;
  assign len      = (cfg.length == 16'd0) ? 16'd1 : cfg.length;
  assign sts.rec  = rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= '0;
      pos_r   <= '0;
      wp_r    <= '0;
      ps_r    <= '0;
      as_r    <= '0;
      ws_r    <= '0;
      trig_r  <= 1'b0;
      done_r  <= 1'b0;
      rec_r   <= 1'b0;
      recs_r  <= '0;
      abase_r <= '0;
      wbase_r <= '0;
    end else begin
      if (cmd.win) begin
        ps_r  <= ps_nxt;
        as_r  <= as_nxt;
        ws_r  <= ws_nxt;
        pos_r <= (pos_r == POS_W'(WINDOW - 1)) ? '0 : pos_r + 1'b1;
      end
      if (cmd.store) begin
        if (n_r == {16'd0, cfg.base_idx}) begin
          abase_r <= aav;
          wbase_r <= wav;
        end
        trig_r <= trig_now;
        rec_r  <= rec_now;
        if (rec_now) begin
          recs_r <= recs_r + 16'd1;
          if ({1'b0, recs_r} + 17'd1 >= {1'b0, len}) done_r <= 1'b1;
        end
        wp_r <= wp_r + 1'b1;
        if (n_r != 32'hFFFF_FFFF) n_r <= n_r + 32'd1;
      end
    end
  end

  // per-record flags, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      short_r <= (n_r < {22'd0, cfg.delay});
      last_r  <= ({1'b0, recs_r} + 17'd1 >= {1'b0, len});
      to_r    <= {1'b0, recs_r} - {7'd0, cfg.delay};
    end
  end

  // pressure conversion
  logic [SAMPLE_BITS+23:0] prod_r;
  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= rd_r[ENT_W-1 -: SAMPLE_BITS] * cfg.gain;
  end

  logic signed [25:0] pv_raw;
  logic signed [16:0] pv;
  assign pv_raw = $signed({2'b00, prod_r[SAMPLE_BITS+23:16]}) - $signed({10'd0, cfg.offset});
  always_comb begin
    if (pv_raw > 26'sd65535)       pv = 17'sd65535;
    else if (pv_raw < -26'sd65536) pv = PEAK_MIN;
    else                           pv = pv_raw[16:0];
  end

  // output register
  logic signed [16:0] peak_r;
  logic               ov_r;
  assign sts.out_free = !ov_r || out_ready;
  assign out_valid    = ov_r;
  assign out_peak_pressure = peak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      peak_r <= PEAK_MIN;
    end else begin
      if (cmd.emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (cmd.emit && !short_r && (pv > peak_r)) peak_r <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_time_offset   <= to_r;
      out_history_short <= short_r;
      out_last_record   <= last_r;
      if (short_r) begin
        out_pressure_value   <= '0;
        out_ignition_delayed <= '0;
        out_arm_relative     <= '0;
        out_wheel_relative   <= '0;
      end else begin
        out_pressure_value   <= pv;
        out_ignition_delayed <= 16'(rd_r[3*SAMPLE_BITS-1 -: SAMPLE_BITS]);
        out_arm_relative     <= {1'b0, rd_r[2*SAMPLE_BITS-1 -: SAMPLE_BITS]} -
                                {1'b0, abase_r};
        out_wheel_relative   <= {1'b0, rd_r[SAMPLE_BITS-1:0]} - {1'b0, wbase_r};
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/triggered_filtered_capture.sv @@
// Channel  | Signals                                  | Transfer when
// in       | in_valid/in_ready + four sample codes    | in_valid & in_ready
// out      | out_valid/out_ready + record fields      | out_valid & out_ready
// cfg      | cfg_psel/penable/pwrite/paddr/pwdata     | psel & penable & pwrite
//
// Each sample runs load, window update, the shared bit-serial averaging
// divider, store, history read, multiply and emit before the next is taken.
// A finished record waits in the output register while the next sample runs;
// only the emit step stalls when that register is still full.
// Reset (rst_n low, synchronous) clears control state; history needs no clear.
`timescale 1ns / 1ps
`default_nettype none
module triggered_filtered_capture
  import tfc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [15:0]       in_pressure_code,
  input  wire logic [15:0]       in_ignition_code,
  input  wire logic [15:0]       in_arm_code,
  input  wire logic [15:0]       in_wheel_code,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [16:0]     out_time_offset,
  output logic signed [16:0]     out_pressure_value,
  output logic [15:0]            out_ignition_delayed,
  output logic signed [16:0]     out_arm_relative,
  output logic signed [16:0]     out_wheel_relative,
  output logic signed [16:0]     out_peak_pressure,
  output logic                   out_history_short,
  output logic                   out_last_record,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [4:0]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t    cfg_r;
  cmd_t    cmd;
  status_t sts;
  logic [2:0] idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thresh   <= 16'd39322;
      cfg_r.delay    <= 10'd1000;
      cfg_r.length   <= 16'd11000;
      cfg_r.base_idx <= 16'd20;
      cfg_r.gain     <= 24'd55555;
      cfg_r.offset   <= 16'd2222;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (idx)
        REG_THRESH: cfg_r.thresh   <= cfg_pwdata[15:0];
        REG_DELAY:  cfg_r.delay    <= cfg_pwdata[9:0];
        REG_LENGTH: cfg_r.length   <= cfg_pwdata[15:0];
        REG_BASE:   cfg_r.base_idx <= cfg_pwdata[15:0];
        REG_GAIN:   cfg_r.gain     <= cfg_pwdata[23:0];
        REG_OFFSET: cfg_r.offset   <= cfg_pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    case (idx)
      REG_THRESH: cfg_prdata = {16'd0, cfg_r.thresh};
      REG_DELAY:  cfg_prdata = {22'd0, cfg_r.delay};
      REG_LENGTH: cfg_prdata = {16'd0, cfg_r.length};
      REG_BASE:   cfg_prdata = {16'd0, cfg_r.base_idx};
      REG_GAIN:   cfg_prdata = {8'd0, cfg_r.gain};
      REG_OFFSET: cfg_prdata = {16'd0, cfg_r.offset};
      default:    cfg_prdata = '0;
    endcase
  end

  tfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tfc_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_pressure_code     (in_pressure_code),
    .in_ignition_code     (in_ignition_code),
    .in_arm_code          (in_arm_code),
    .in_wheel_code        (in_wheel_code),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_time_offset      (out_time_offset),
    .out_pressure_value   (out_pressure_value),
    .out_ignition_delayed (out_ignition_delayed),
    .out_arm_relative     (out_arm_relative),
    .out_wheel_relative   (out_wheel_relative),
    .out_peak_pressure    (out_peak_pressure),
    .out_history_short    (out_history_short),
    .out_last_record      (out_last_record)
  );

endmodule
`default_nettype wire

@@ rtl/core/tfc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tfc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [16:0] out_time_offset,
  input wire logic [16:0] out_pressure_value,
  input wire logic [15:0] out_ignition_delayed,
  input wire logic        out_history_short,
  input wire logic        out_last_record
);

  // a stalled record stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("record dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_time_offset))
    else $error("stalled record changed");

  // one sample at a time
  a_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while busy");

  // nothing follows the final record
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_record |=> !out_valid)
    else $error("record after end of capture");

  // short history zeroes the values
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_history_short |->
      out_pressure_value == 17'd0 && out_ignition_delayed == 16'd0)
    else $error("short history record carries data");

endmodule

bind triggered_filtered_capture tfc_checker u_tfc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_time_offset      (out_time_offset),
  .out_pressure_value   (out_pressure_value),
  .out_ignition_delayed (out_ignition_delayed),
  .out_history_short    (out_history_short),
  .out_last_record      (out_last_record)
);
`default_nettype wire
